@@ design/pll_pkg.sv @@
// package for the positional linked list engine
// holds sizes, request codes, transaction structs and control structs
// no dependencies
`default_nettype none

package pll_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int PTR_W    = IDX_W + 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 7;
	localparam int TYPE_W   = 2;

	localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);

	typedef enum logic [TYPE_W-1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_GET    = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_type_t;

	typedef struct packed {
		logic [TYPE_W-1:0]        req_type;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic                     success;
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_W-1:0]         length;
	} rsp_t;

	typedef struct packed {
		logic             rd;
		logic             wr;
		logic             clr;
		logic [IDX_W-1:0] addr;
		logic [IDX_W-1:0] wdata;
	} fs_cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]  rd_addr;
		logic              nxt_we;
		logic [IDX_W-1:0]  nxt_waddr;
		logic [PTR_W-1:0]  nxt_wdata;
		logic              val_we;
		logic [IDX_W-1:0]  val_waddr;
		logic [DATA_W-1:0] val_wdata;
	} slot_cmd_t;

endpackage

`default_nettype wire

@@ design/pll_free_stack.sv @@
// free slot stack for the positional linked list engine
// one memory with registered read, identity below the low-water mark
// depends on pll_pkg
`default_nettype none

module pll_free_stack (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pll_pkg::fs_cmd_t              cmd,
	output logic [pll_pkg::IDX_W-1:0]          slot
);

	logic [pll_pkg::IDX_W-1:0] mem [pll_pkg::CAPACITY];
	logic [pll_pkg::IDX_W-1:0] mem_rd_q;
	logic [pll_pkg::IDX_W-1:0] addr_q;
	logic                      ident_q;
	logic [pll_pkg::CNT_W-1:0] low_mark_q;

	// stack entries below the low-water mark were never popped since clear
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[cmd.addr] <= cmd.wdata;
		end
		if (cmd.rd) begin
			mem_rd_q <= mem[cmd.addr];
			addr_q   <= cmd.addr;
			ident_q  <= (pll_pkg::CNT_W'(cmd.addr) < low_mark_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_mark_q <= pll_pkg::CNT_W'(pll_pkg::CAPACITY);
		end else if (cmd.clr) begin
			low_mark_q <= pll_pkg::CNT_W'(pll_pkg::CAPACITY);
		end else if (cmd.rd && (pll_pkg::CNT_W'(cmd.addr) < low_mark_q)) begin
			low_mark_q <= pll_pkg::CNT_W'(cmd.addr);
		end
	end

	assign slot = ident_q ? addr_q : mem_rd_q;

endmodule

`default_nettype wire

@@ design/pll_slot_store.sv @@
// slot storage for the positional linked list engine
// value and next-link memories, one shared read address, registered read data
// depends on pll_pkg
`default_nettype none

module pll_slot_store (
	input  wire logic                          clk,
	input  wire pll_pkg::slot_cmd_t            cmd,
	output logic [pll_pkg::PTR_W-1:0]          next_rdata,
	output logic [pll_pkg::DATA_W-1:0]         value_rdata
);

	logic [pll_pkg::PTR_W-1:0]  next_mem  [pll_pkg::CAPACITY];
	logic [pll_pkg::DATA_W-1:0] value_mem [pll_pkg::CAPACITY];
	logic [pll_pkg::PTR_W-1:0]  next_rdata_q;
	logic [pll_pkg::DATA_W-1:0] value_rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.nxt_we) begin
			next_mem[cmd.nxt_waddr] <= cmd.nxt_wdata;
		end
		next_rdata_q <= next_mem[cmd.rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.val_we) begin
			value_mem[cmd.val_waddr] <= cmd.val_wdata;
		end
		value_rdata_q <= value_mem[cmd.rd_addr];
	end

	assign next_rdata  = next_rdata_q;
	assign value_rdata = value_rdata_q;

endmodule

`default_nettype wire

@@ design/positional_linked_list_engine.sv @@
// top level of the positional linked list engine
// sequencer that walks the links, plus the result register
// depends on pll_pkg, pll_free_stack, pll_slot_store
`default_nettype none

// Keeps an ordered list of up to 64 signed 32-bit values as linked slots with a
// free slot stack, and answers one request at a time with one result. The walk
// follows one next-link per cycle through the slot memory toward the request
// position: a get or an insert passes S_RD and S_WALK (an insert at the head
// skips both), an insert then fills its slot in S_LINK, a remove passes S_RD
// and S_WALK twice (once at the head); a failed request or a clear goes
// straight to S_OUT. req_stall is high while a request is in progress; a
// finished result waits in its own register, so the next request is taken
// while rsp is stalled. No clearing pass is needed after reset.
module positional_linked_list_engine (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire pll_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output pll_pkg::rsp_t      rsp
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_WALK = 5'b00100,
		S_LINK = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t                     state_q;
	logic [pll_pkg::TYPE_W-1:0] op_q;
	logic                       phase_q;
	logic                       at_head_q;
	logic [pll_pkg::PTR_W-1:0]  cur_q;
	logic [pll_pkg::PTR_W-1:0]  prev_q;
	logic [pll_pkg::PTR_W-1:0]  tmp_q;
	logic [pll_pkg::POS_W-1:0]  hops_q;
	logic [pll_pkg::DATA_W-1:0] val_q;
	logic [pll_pkg::CNT_W-1:0]  count_q;
	logic [pll_pkg::PTR_W-1:0]  head_q;
	logic                       ok_q;
	logic [pll_pkg::DATA_W-1:0] rd_q;
	logic                       rsp_valid_q;
	pll_pkg::rsp_t              rsp_q;

	pll_pkg::fs_cmd_t           fs_cmd;
	pll_pkg::slot_cmd_t         slot_cmd;
	logic [pll_pkg::IDX_W-1:0]  fs_slot;
	logic [pll_pkg::PTR_W-1:0]  next_rdata;
	logic [pll_pkg::DATA_W-1:0] value_rdata;

	logic                       accept;
	logic                       walk_end;
	logic                       rsp_load;
	logic                       ins_ok;
	logic                       pos_ok;
	logic [pll_pkg::CNT_W-1:0]  free_top;
	logic [pll_pkg::IDX_W-1:0]  pop_addr;
	logic [pll_pkg::IDX_W-1:0]  push_addr;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign walk_end  = (state_q == S_WALK) && (hops_q == '0);
	assign rsp_load  = (state_q == S_OUT) && (!rsp_valid_q || !rsp_stall);

	assign free_top  = pll_pkg::CNT_W'(pll_pkg::CAPACITY) - count_q;
	assign pop_addr  = pll_pkg::IDX_W'(free_top - pll_pkg::CNT_W'(1));
	assign push_addr = pll_pkg::IDX_W'(free_top);

	assign ins_ok = (pll_pkg::CNT_W'(req.position) <= count_q)
		&& (count_q < pll_pkg::CNT_W'(pll_pkg::CAPACITY));
	assign pos_ok = (pll_pkg::CNT_W'(req.position) < count_q);

	pll_free_stack u_free_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (fs_cmd),
		.slot   (fs_slot)
	);

	pll_slot_store u_slot_store (
		.clk         (clk),
		.cmd         (slot_cmd),
		.next_rdata  (next_rdata),
		.value_rdata (value_rdata)
	);

	always_comb begin
		fs_cmd   = '0;
		slot_cmd = '0;

		slot_cmd.rd_addr = (state_q == S_WALK) ? next_rdata[pll_pkg::IDX_W-1:0]
			: cur_q[pll_pkg::IDX_W-1:0];

		if (accept) begin
			if ((req.req_type == pll_pkg::REQ_INSERT) && ins_ok) begin
				fs_cmd.rd   = 1'b1;
				fs_cmd.addr = pop_addr;
			end
			if (req.req_type == pll_pkg::REQ_CLEAR) begin
				fs_cmd.clr = 1'b1;
			end
		end

		if (walk_end) begin
			if (op_q == pll_pkg::REQ_INSERT) begin
				slot_cmd.nxt_we    = 1'b1;
				slot_cmd.nxt_waddr = cur_q[pll_pkg::IDX_W-1:0];
				slot_cmd.nxt_wdata = {1'b0, fs_slot};
			end else if ((op_q == pll_pkg::REQ_REMOVE) && phase_q) begin
				slot_cmd.nxt_we    = !at_head_q;
				slot_cmd.nxt_waddr = prev_q[pll_pkg::IDX_W-1:0];
				slot_cmd.nxt_wdata = next_rdata;
				fs_cmd.wr          = 1'b1;
				fs_cmd.addr        = push_addr;
				fs_cmd.wdata       = cur_q[pll_pkg::IDX_W-1:0];
			end
		end

		if (state_q == S_LINK) begin
			slot_cmd.nxt_we    = 1'b1;
			slot_cmd.nxt_waddr = fs_slot;
			slot_cmd.nxt_wdata = tmp_q;
			slot_cmd.val_we    = 1'b1;
			slot_cmd.val_waddr = fs_slot;
			slot_cmd.val_wdata = val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= pll_pkg::NULL_PTR;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.req_type) inside
							pll_pkg::REQ_INSERT: begin
								state_q <= !ins_ok ? S_OUT
									: ((req.position == '0) ? S_LINK : S_RD);
							end
							pll_pkg::REQ_REMOVE, pll_pkg::REQ_GET: begin
								state_q <= pos_ok ? S_RD : S_OUT;
							end
							default: begin
								count_q <= '0;
								head_q  <= pll_pkg::NULL_PTR;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (walk_end) begin
						case (op_q)
							pll_pkg::REQ_INSERT: begin
								state_q <= S_LINK;
							end
							pll_pkg::REQ_REMOVE: begin
								if (phase_q) begin
									if (at_head_q) begin
										head_q <= next_rdata;
									end
									count_q <= count_q - pll_pkg::CNT_W'(1);
									state_q <= S_OUT;
								end else begin
									state_q <= S_RD;
								end
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_LINK: begin
					if (at_head_q) begin
						head_q <= {1'b0, fs_slot};
					end
					count_q <= count_q + pll_pkg::CNT_W'(1);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// walk and result datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= req.req_type;
			val_q     <= req.value;
			cur_q     <= head_q;
			tmp_q     <= head_q;
			rd_q      <= '0;
			at_head_q <= (req.position == '0);
			phase_q   <= (req.position == '0);
			hops_q    <= (req.req_type == pll_pkg::REQ_GET) ? req.position
				: ((req.position == '0) ? '0 : req.position - pll_pkg::POS_W'(1));
			case (req.req_type) inside
				pll_pkg::REQ_INSERT: ok_q <= ins_ok;
				pll_pkg::REQ_REMOVE,
				pll_pkg::REQ_GET:    ok_q <= pos_ok;
				default:             ok_q <= 1'b1;
			endcase
		end

		if ((state_q == S_WALK) && !walk_end) begin
			cur_q  <= next_rdata;
			hops_q <= hops_q - pll_pkg::POS_W'(1);
		end

		if (walk_end) begin
			case (op_q)
				pll_pkg::REQ_INSERT: begin
					tmp_q <= next_rdata;
				end
				pll_pkg::REQ_REMOVE: begin
					if (!phase_q) begin
						prev_q  <= cur_q;
						cur_q   <= next_rdata;
						phase_q <= 1'b1;
					end
				end
				pll_pkg::REQ_GET: begin
					rd_q <= value_rdata;
				end
				default: begin
					rd_q <= '0;
				end
			endcase
		end

		if (rsp_load) begin
			rsp_q.success    <= ok_q;
			rsp_q.read_value <= rd_q;
			rsp_q.length     <= count_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

@@ bench/pll_checker.sv @@
// checker for the positional linked list engine: watches both channels,
// keeps its own copy of the list and compares every response field by field
// depends on pll_pkg
`default_nettype none

module pll_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	input  wire logic          req_stall,
	input  wire pll_pkg::req_t req,
	input  wire logic          rsp_valid,
	input  wire logic          rsp_stall,
	input  wire pll_pkg::rsp_t rsp,
	output int                 mismatches,
	output int                 outstanding
);

	logic signed [pll_pkg::DATA_W-1:0] list_entries[$];
	pll_pkg::rsp_t                     expected_rsp[$];
	pll_pkg::rsp_t                     oldest;

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	// applies one request to the list copy and returns the response it gives
	function automatic pll_pkg::rsp_t apply_request(input pll_pkg::req_t r);
		pll_pkg::rsp_t o;
		int            pos;
		int            len;
		o   = '0;
		pos = int'(r.position);
		len = list_entries.size();
		case (pll_pkg::req_type_t'(r.req_type))
			pll_pkg::REQ_INSERT: begin
				if (pos <= len && len < pll_pkg::CAPACITY) begin
					list_entries.insert(pos, r.value);
					o.success = 1'b1;
				end
			end
			pll_pkg::REQ_REMOVE: begin
				if (pos < len) begin
					list_entries.delete(pos);
					o.success = 1'b1;
				end
			end
			pll_pkg::REQ_GET: begin
				if (pos < len) begin
					o.read_value = list_entries[pos];
					o.success    = 1'b1;
				end
			end
			default: begin
				list_entries.delete();
				o.success = 1'b1;
			end
		endcase
		o.length = pll_pkg::CNT_W'(list_entries.size());
		return o;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			list_entries.delete();
			expected_rsp.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					report_mismatch($sformatf("response with nothing expected: %h", rsp));
				end else begin
					oldest = expected_rsp.pop_front();
					if (rsp.success !== oldest.success)
						report_mismatch($sformatf("success: expected %0b, got %0b",
							oldest.success, rsp.success));
					if (rsp.read_value !== oldest.read_value)
						report_mismatch($sformatf("read_value: expected %0d, got %0d",
							oldest.read_value, rsp.read_value));
					if (rsp.length !== oldest.length)
						report_mismatch($sformatf("length: expected %0d, got %0d",
							oldest.length, rsp.length));
				end
			end
			if (req_valid && !req_stall)
				expected_rsp.push_back(apply_request(req));
			outstanding = expected_rsp.size();
		end
	end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
// top of the bench for the positional linked list engine: clock, reset,
// request stimulus with random gaps, response back-pressure and the verdict
// depends on pll_pkg, positional_linked_list_engine, pll_checker
`default_nettype none

module testbench;

	localparam int RANDOM_ITEMS = 1450;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT   = 5000;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	pll_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	pll_pkg::rsp_t rsp;
	int            mismatches;
	int            outstanding;

	bit   steady  = 1'b0;
	bit   holding = 1'b0;
	int   list_len = 0;
	int   idle_cycles = 0;
	event hold_start;

	positional_linked_list_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	pll_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// response side back-pressure
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (holding)
				rsp_stall = 1'b1;
			else if (steady)
				rsp_stall = 1'b0;
			else
				rsp_stall = ($urandom_range(99) < 18);
		end
	end

	// long response hold-off so the engine fills and stalls requests
	initial begin
		forever begin
			@(hold_start);
			holding = 1'b1;
			repeat (HOLD_CYCLES) @(negedge clk);
			holding = 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// tracks the list length so positions can be aimed at the edges
	task automatic send_request(input pll_pkg::req_type_t kind, input int pos,
		input logic [31:0] val);
		pll_pkg::req_t item;
		item.req_type = kind;
		item.position = pll_pkg::POS_W'(pos);
		item.value    = val;
		case (kind)
			pll_pkg::REQ_INSERT:
				if (pos <= list_len && list_len < pll_pkg::CAPACITY) list_len++;
			pll_pkg::REQ_REMOVE: if (pos < list_len) list_len--;
			pll_pkg::REQ_CLEAR:  list_len = 0;
			default: ;
		endcase
		while (!steady && $urandom_range(99) < 18) begin
			req_valid = 1'b0;
			@(negedge clk);
		end
		req_valid = 1'b1;
		req       = item;
		do
			@(posedge clk);
		while (req_stall);
		@(negedge clk);
	endtask

	function automatic int choose_position(input pll_pkg::req_type_t kind, input int len);
		int roll;
		roll = $urandom_range(99);
		if (roll < 8)
			return $urandom_range(127);
		if (kind == pll_pkg::REQ_INSERT) begin
			if (roll < 14)
				return len + 1;
			if (roll < 24)
				return len;
			return $urandom_range(len);
		end
		if (roll < 14 || len == 0)
			return len;
		if (roll < 22)
			return len - 1;
		return $urandom_range(len - 1);
	endfunction

	initial begin
		int                 n;
		int                 roll;
		int                 phase;
		pll_pkg::req_type_t kind;

		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty list corners
		send_request(pll_pkg::REQ_GET,    0, 32'h0);
		send_request(pll_pkg::REQ_REMOVE, 0, 32'h0);
		send_request(pll_pkg::REQ_INSERT, 1, 32'h1);
		// front, back and middle inserts with extreme values, an out of range insert, then gets
		send_request(pll_pkg::REQ_INSERT, 0, 32'h7fff_ffff);
		send_request(pll_pkg::REQ_INSERT, 1, 32'h8000_0000);
		send_request(pll_pkg::REQ_INSERT, 0, 32'hffff_ffff);
		send_request(pll_pkg::REQ_INSERT, 1, 32'h0);
		send_request(pll_pkg::REQ_INSERT, 127, 32'h5);
		send_request(pll_pkg::REQ_GET,    0, 32'h0);
		send_request(pll_pkg::REQ_GET,    1, 32'h0);
		send_request(pll_pkg::REQ_GET,    2, 32'h0);
		send_request(pll_pkg::REQ_GET,    3, 32'h0);
		send_request(pll_pkg::REQ_GET,    4, 32'h0);
		send_request(pll_pkg::REQ_GET,    127, 32'hffff_ffff);
		// middle and last removes, then out of range
		send_request(pll_pkg::REQ_REMOVE, 1, 32'h0);
		send_request(pll_pkg::REQ_REMOVE, 2, 32'h0);
		send_request(pll_pkg::REQ_REMOVE, 5, 32'h0);
		send_request(pll_pkg::REQ_GET,    0, 32'h0);
		send_request(pll_pkg::REQ_GET,    1, 32'h0);
		// clear on a non-empty and an empty list
		send_request(pll_pkg::REQ_CLEAR,  127, 32'hffff_ffff);
		send_request(pll_pkg::REQ_CLEAR,  0, 32'h0);
		send_request(pll_pkg::REQ_INSERT, 0, 32'h5555_5555);
		send_request(pll_pkg::REQ_GET,    0, 32'haaaa_aaaa);
		send_request(pll_pkg::REQ_REMOVE, 0, 32'h0);

		req_valid = 1'b0;
		wait (outstanding == 0);
		@(negedge clk);

		// phases rotate between filling, mixed traffic and draining
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300)
				-> hold_start;
			if (n == 900) begin
				req_valid = 1'b0;
				wait (outstanding == 0);
				@(negedge clk);
			end
			steady = (n >= 500 && n < 700);
			phase  = (n / 150) % 3;
			roll   = $urandom_range(99);
			if (phase == 0)
				kind = (roll < 72) ? pll_pkg::REQ_INSERT
					: (roll < 80) ? pll_pkg::REQ_REMOVE : pll_pkg::REQ_GET;
			else if (phase == 1)
				kind = (roll < 40) ? pll_pkg::REQ_INSERT
					: (roll < 75) ? pll_pkg::REQ_REMOVE
					: (roll < 98) ? pll_pkg::REQ_GET : pll_pkg::REQ_CLEAR;
			else
				kind = (roll < 20) ? pll_pkg::REQ_INSERT
					: (roll < 75) ? pll_pkg::REQ_REMOVE : pll_pkg::REQ_GET;
			send_request(kind, choose_position(kind, list_len), $urandom);
		end
		steady    = 1'b0;
		req_valid = 1'b0;

		wait (outstanding == 0);
		repeat (80) @(negedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
design/pll_pkg.sv
design/pll_free_stack.sv
design/pll_slot_store.sv
design/positional_linked_list_engine.sv
bench/pll_checker.sv
bench/testbench.sv
